// ----- rtl/core/pce_pkg.sv -----
// Package with shared constants, code tables and types of the perforator character encoder.
package pce_pkg;

	// Field widths.
	localparam int CP_W   = 21;
	localparam int CODE_W = 5;

	// Comment nesting limit and the depth counter width that follows from it.
	localparam int MAX_NESTING = 255;
	localparam int DEPTH_W     = $clog2(MAX_NESTING + 1);

	// Number of entries in each shift table.
	localparam int TAB_N = 32;

	// Characters with a special meaning.
	localparam logic [CP_W-1:0] CH_NULL   = 21'h000000;
	localparam logic [CP_W-1:0] CH_OPEN   = 21'h00005B;
	localparam logic [CP_W-1:0] CH_CLOSE  = 21'h00005D;
	localparam logic [CP_W-1:0] CH_BSLASH = 21'h00005C;
	localparam logic [CP_W-1:0] CH_TILDE  = 21'h00007E;

	// Escape followers.
	localparam logic [CP_W-1:0] ESC_CH_P    = 21'h000070;
	localparam logic [CP_W-1:0] ESC_CH_S    = 21'h000073;
	localparam logic [CP_W-1:0] ESC_CH_E    = 21'h000065;
	localparam logic [CP_W-1:0] ESC_CH_STAR = 21'h00002A;
	localparam logic [CP_W-1:0] ESC_CH_H    = 21'h000068;
	localparam logic [CP_W-1:0] ESC_CH_F    = 21'h000066;
	localparam logic [CP_W-1:0] ESC_CH_D    = 21'h000064;

	// Tape codes given by the escape followers.
	localparam logic [CODE_W-1:0] ESC_CODE_P = 5'h1B;
	localparam logic [CODE_W-1:0] ESC_CODE_S = 5'h1D;
	localparam logic [CODE_W-1:0] ESC_CODE_E = 5'h1F;
	localparam logic [CODE_W-1:0] ESC_CODE_H = 5'h02;
	localparam logic [CODE_W-1:0] ESC_CODE_F = 5'h04;
	localparam logic [CODE_W-1:0] ESC_CODE_D = 5'h08;

	// Letter shift characters in code order.
	localparam logic [CP_W-1:0] LETTER_TAB [TAB_N] = '{
		21'h2E, 21'h46, 21'h398, 21'h44, 21'h3A6, 21'h48, 21'h4E, 21'h4D,
		21'h394, 21'h4C, 21'h58, 21'h47, 21'h41, 21'h42, 21'h43, 21'h56,
		21'h50, 21'h51, 21'h57, 21'h45, 21'h52, 21'h54, 21'h59, 21'h55,
		21'h49, 21'h4F, 21'h4A, 21'h3A0, 21'h53, 21'h5A, 21'h4B, 21'h2A
	};

	// Figure shift characters in code order; zero marks an unused slot.
	localparam logic [CP_W-1:0] FIGURE_TAB [TAB_N] = '{
		21'h2E, 21'h00, 21'h40, 21'h2C, 21'h21, 21'h2B, 21'h2D, 21'h27,
		21'h26, 21'h25, 21'h00, 21'h00, 21'h3A, 21'h3F, 21'h28, 21'h29,
		21'h30, 21'h31, 21'h32, 21'h33, 21'h34, 21'h35, 21'h36, 21'h37,
		21'h38, 21'h39, 21'h07, 21'h23, 21'h27, 21'hA7, 21'h28, 21'h2A
	};

	// Outcome of translating one character.
	typedef struct packed {
		logic              hit;
		logic [CODE_W-1:0] code;
		logic              esc_next;
	} pce_xlat_t;

endpackage

// ----- rtl/core/pce_translate.sv -----
// Character to tape code translation: escape handling, case folding and table search.
module pce_translate (
	input  logic [pce_pkg::CP_W-1:0] ch,
	input  logic                     esc_pending,
	output pce_pkg::pce_xlat_t       xlat
);
	import pce_pkg::*;

	logic [CP_W-1:0]   upper_ch;
	logic              letter_hit;
	logic [CODE_W-1:0] letter_idx;
	logic              figure_hit;
	logic [CODE_W-1:0] figure_idx;

	// Fold ASCII lower case and the four Greek small letters to capitals.
	always_comb begin
		if ((ch >= 21'h61 && ch <= 21'h7A) || ch == 21'h3C0 || ch == 21'h3B8 ||
		    ch == 21'h3C6 || ch == 21'h3B4) begin
			upper_ch = ch - 21'h20;
		end else begin
			upper_ch = ch;
		end
	end

	// Search both tables; walking downward leaves the lowest matching slot.
	always_comb begin
		letter_hit = 1'b0;
		letter_idx = '0;
		figure_hit = 1'b0;
		figure_idx = '0;
		for (int i = TAB_N - 1; i >= 0; i--) begin
			if (LETTER_TAB[i] == upper_ch) begin
				letter_hit = 1'b1;
				letter_idx = CODE_W'(i);
			end
			if (FIGURE_TAB[i] != CH_NULL && FIGURE_TAB[i] == ch) begin
				figure_hit = 1'b1;
				figure_idx = CODE_W'(i);
			end
		end
	end

	// Pending escape first, then backslash, dropped null/tilde, letters, figures.
	always_comb begin
		xlat.hit      = 1'b0;
		xlat.code     = '0;
		xlat.esc_next = esc_pending;
		if (esc_pending) begin
			xlat.esc_next = 1'b0;
			xlat.hit      = 1'b1;
			unique case (ch)
				ESC_CH_P:             xlat.code = ESC_CODE_P;
				ESC_CH_S:             xlat.code = ESC_CODE_S;
				ESC_CH_E, ESC_CH_STAR: xlat.code = ESC_CODE_E;
				ESC_CH_H:             xlat.code = ESC_CODE_H;
				ESC_CH_F:             xlat.code = ESC_CODE_F;
				ESC_CH_D:             xlat.code = ESC_CODE_D;
				default:              xlat.hit  = 1'b0;
			endcase
		end else if (ch == CH_BSLASH) begin
			xlat.esc_next = 1'b1;
		end else if (ch == CH_NULL || ch == CH_TILDE) begin
			xlat.hit = 1'b0;
		end else if (letter_hit) begin
			xlat.hit  = 1'b1;
			xlat.code = letter_idx;
		end else if (figure_hit) begin
			xlat.hit  = 1'b1;
			xlat.code = figure_idx;
		end
	end

endmodule

// ----- rtl/core/perforator_char_encoder_top.sv -----
// Top level of the perforator character encoder.
//
// Input channel: in_valid / in_ready carry one beat per character, with the
// Unicode code point and the direct flag. Output channel: out_valid /
// out_ready carry one beat per tape code produced. A character gives zero
// or one tape code; dropped characters produce no output beat.
// Each beat first lands in an input register; the translation and the
// comment and escape state update run combinationally from it and write
// the output register when that register is free, so a tape code passes
// through the input register and then the output register. One beat can
// be taken every cycle while the receiver does not stall.
// When the receiver stalls with a code waiting, the input register holds
// its beat and in_ready falls only once that register is also occupied.
// Reset clears the comment depth, the pending escape and both valid flags;
// no clearing pass is needed.
module perforator_char_encoder_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [pce_pkg::CP_W-1:0]   code_point,
	input  logic                       direct,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [pce_pkg::CODE_W-1:0] tape_code
);
	import pce_pkg::*;

	logic                valid_s1;
	logic [CP_W-1:0]     cp_s1;
	logic                direct_s1;
	logic                out_valid_q;
	logic [CODE_W-1:0]   tape_code_q;
	logic [DEPTH_W-1:0]  depth_q;
	logic                esc_q;

	logic                out_free;
	logic                advance;
	logic                emit;
	logic [DEPTH_W-1:0]  depth_next;
	logic                esc_next;
	pce_xlat_t           xlat;

	// Handshake: the input register moves on whenever the output register is free.
	assign out_free = !out_valid_q || out_ready;
	assign advance  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || advance;

	pce_translate u_translate (
		.ch          (cp_s1),
		.esc_pending (esc_q),
		.xlat        (xlat)
	);

	// Comment bracket handling on the stream path, then translation.
	always_comb begin
		depth_next = depth_q;
		esc_next   = esc_q;
		emit       = 1'b0;
		if (!direct_s1 && cp_s1 == CH_OPEN) begin
			if (depth_q < DEPTH_W'(MAX_NESTING)) begin
				depth_next = depth_q + 1'b1;
			end
		end else if (!direct_s1 && cp_s1 == CH_CLOSE && depth_q != '0) begin
			depth_next = depth_q - 1'b1;
		end else if (!direct_s1 && depth_q != '0) begin
			emit = 1'b0;
		end else begin
			esc_next = xlat.esc_next;
			emit     = xlat.hit;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cp_s1     <= code_point;
			direct_s1 <= direct;
		end
	end

	// Comment depth and escape state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			esc_q   <= 1'b0;
		end else if (advance) begin
			depth_q <= depth_next;
			esc_q   <= esc_next;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			tape_code_q <= xlat.code;
		end
	end

	assign out_valid = out_valid_q;
	assign tape_code = tape_code_q;

endmodule
